### hw/rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared constants for the stroke ribbon tessellator datapath.
// ----------------------------------------------------------------------------
package srt_pkg;

    // the larger normalized direction magnitude lies in [2^NORM_LO_BIT, 2^NORM_BITS)
    localparam int NORM_BITS   = 21;
    localparam int NORM_LO_BIT = 20;

    // accumulator for squares, root and division
    localparam int ACC_W       = 44;
    localparam int ROOT_W      = 22;
    localparam int ROOT_START  = 42;

endpackage

### hw/rtl/srt_if.sv
// ----------------------------------------------------------------------------
// srt_point_if / srt_vert_if
// Valid/ready channels for pen points in and strip vertices out.
// ----------------------------------------------------------------------------
interface srt_point_if #(
    parameter int COORD_BITS = 24,
    parameter int WIDTH_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic        [WIDTH_BITS-1:0] point_width;
    logic                         stroke_end;

    modport source (output valid, point_x, point_y, point_width, stroke_end, input ready);
    modport sink   (input valid, point_x, point_y, point_width, stroke_end, output ready);
endinterface

interface srt_vert_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vert_x;
    logic signed [COORD_BITS-1:0] vert_y;
    logic                         strip_done;
    logic                         run_last;

    modport source (output valid, vert_x, vert_y, strip_done, run_last, input ready);
    modport sink   (input valid, vert_x, vert_y, strip_done, run_last, output ready);
endinterface

### hw/rtl/stroke_ribbon_tessellator.sv
// ----------------------------------------------------------------------------
// stroke_ribbon_tessellator
// Turns pen points into triangle-strip vertices of a variable width ribbon.
// ----------------------------------------------------------------------------
// One point is taken per transaction; its two vertices come out when the next
// point arrives, a final point flushes four vertices, and a lone final point
// gives a four-vertex square. All arithmetic runs through one shared 21x21
// multiplier, a one-bit-per-cycle square root and a restoring divider under a
// small sequencer, and the block is not ready while it works. A direction
// pair runs through the accept or hand-over step, the normalizing shifts and
// the step that ends them, two squares, the root steps, a multiply and divide
// pass for each axis and the two vertices, which wait on any output stall; a
// final point after others runs two pairs back to back, while a first point is
// only stored and a lone final point goes straight to its four vertices.
// ----------------------------------------------------------------------------
module stroke_ribbon_tessellator #(
    parameter int COORD_BITS = 24,
    parameter int WIDTH_BITS = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srt_point_if.sink   i_point,
    srt_vert_if.source  o_vert
);

    localparam int CB  = COORD_BITS;
    localparam int WB  = WIDTH_BITS;
    localparam int MB  = CB + 1;
    localparam int NB  = (MB > srt_pkg::NORM_BITS) ? MB : srt_pkg::NORM_BITS;
    localparam int AW  = srt_pkg::ACC_W;
    localparam int NRM = srt_pkg::NORM_BITS;
    localparam int SW  = ((CB > WB + 1) ? CB : WB + 1) + 2;
    localparam int CW  = (WB > 1) ? $clog2(WB) : 1;

    localparam logic signed [SW-1:0] SMAX = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-CB+1){1'b1}}, {(CB-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SQA, S_SQB, S_ROOT, S_MULY, S_DIVX, S_MULX, S_DIVY, S_EMIT
    } t_state;

    t_state r_state;

    logic signed [CB-1:0] r_bx, r_by, r_hx, r_hy, r_cx, r_cy;
    logic        [WB-1:0] r_hw, r_cw, r_ox, r_quo;
    logic        [1:0]    r_seen, r_vi;
    logic        [NB-1:0] r_ax, r_ay;
    logic                 r_negx, r_negy, r_done, r_last, r_second, r_sq;
    logic        [AW-1:0] r_acc, r_rem, r_root, r_bit, r_den;
    logic        [CW-1:0] r_cnt;
    logic signed [WB:0]   r_ux, r_uy;

    logic                 r_ov, r_odone, r_olast;
    logic signed [CB-1:0] r_oxv, r_oyv;

    // direction setup
    logic signed [CB-1:0] j_ax, j_ay, j_bx, j_by;
    logic signed [MB-1:0] j_dx, j_dy;
    logic        [MB-1:0] j_mx, j_my;
    logic                 j_nx, j_ny, j_zero;

    always_comb begin
        if (r_state == S_IDLE) begin
            j_ax = i_point.point_x;
            j_ay = i_point.point_y;
            j_bx = (r_seen == 2'd1) ? r_hx : r_bx;
            j_by = (r_seen == 2'd1) ? r_hy : r_by;
        end else begin
            j_ax = r_hx;
            j_ay = r_hy;
            j_bx = r_bx;
            j_by = r_by;
        end
        j_dx   = MB'(j_ax) - MB'(j_bx);
        j_dy   = MB'(j_ay) - MB'(j_by);
        j_nx   = j_dx[MB-1];
        j_ny   = j_dy[MB-1];
        j_mx   = j_nx ? MB'(-j_dx) : MB'(j_dx);
        j_my   = j_ny ? MB'(-j_dy) : MB'(j_dy);
        j_zero = (j_dx == '0) && (j_dy == '0);
    end

    // shared datapath
    logic [NB-1:0]      m_max;
    logic               m_big, m_small;
    logic [NRM-1:0]     mul_a, mul_b;
    logic [2*NRM-1:0]   mul_p;
    logic [AW-1:0]      len, rt_t, acc_ge_sum;
    logic               div_ge;

    always_comb begin
        m_max   = (r_ax > r_ay) ? r_ax : r_ay;
        m_big   = ((NB+1)'(m_max) >= (NB+1)'(2**NRM));
        m_small = (m_max < NB'(2**srt_pkg::NORM_LO_BIT));
        case (r_state)
            S_SQA:   begin mul_a = r_ax[NRM-1:0]; mul_b = r_ax[NRM-1:0]; end
            S_SQB:   begin mul_a = r_ay[NRM-1:0]; mul_b = r_ay[NRM-1:0]; end
            S_MULY:  begin mul_a = r_ay[NRM-1:0]; mul_b = NRM'(r_cw); end
            default: begin mul_a = r_ax[NRM-1:0]; mul_b = NRM'(r_cw); end
        endcase
        mul_p      = mul_a * mul_b;
        len        = AW'(r_root[srt_pkg::ROOT_W-1:0]);
        rt_t       = r_root + r_bit;
        acc_ge_sum = AW'(mul_p) + len;
        div_ge     = (r_acc >= r_den);
    end

    // vertex output
    logic                 e_nx, e_ny, e_fin;
    logic signed [SW-1:0] e_sx, e_sy, e_ux, e_uy;
    logic signed [CB-1:0] e_vx, e_vy;
    logic                 out_free;

    always_comb begin
        e_nx  = r_sq ? !r_vi[0] : r_vi[0];
        e_ny  = r_sq ? !r_vi[1] : r_vi[0];
        e_fin = r_sq ? (r_vi == 2'd3) : r_vi[0];
        e_ux  = SW'(r_ux);
        e_uy  = SW'(r_uy);
        e_sx  = SW'(r_cx) + (e_nx ? -e_ux : e_ux);
        e_sy  = SW'(r_cy) + (e_ny ? -e_uy : e_uy);
        e_vx  = (e_sx > SMAX) ? SMAX[CB-1:0] : ((e_sx < SMIN) ? SMIN[CB-1:0] : e_sx[CB-1:0]);
        e_vy  = (e_sy > SMAX) ? SMAX[CB-1:0] : ((e_sy < SMIN) ? SMIN[CB-1:0] : e_sy[CB-1:0]);
        out_free = !r_ov || o_vert.ready;
    end

    assign i_point.ready     = (r_state == S_IDLE);
    assign o_vert.valid      = r_ov;
    assign o_vert.vert_x     = r_oxv;
    assign o_vert.vert_y     = r_oyv;
    assign o_vert.strip_done = r_odone;
    assign o_vert.run_last   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen  <= 2'd0;
            r_bx    <= '0;
            r_by    <= '0;
            r_hx    <= '0;
            r_hy    <= '0;
            r_hw    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_vert.ready && !((r_state == S_EMIT) && out_free)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_point.valid) begin
                        if (r_seen == 2'd0) begin
                            if (i_point.stroke_end) begin
                                r_cx    <= i_point.point_x;
                                r_cy    <= i_point.point_y;
                                r_ux    <= (WB+1)'(({1'b0, i_point.point_width} + 1'b1) >> 1);
                                r_uy    <= (WB+1)'(({1'b0, i_point.point_width} + 1'b1) >> 1);
                                r_sq    <= 1'b1;
                                r_vi    <= 2'd0;
                                r_state <= S_EMIT;
                            end else begin
                                r_hx   <= i_point.point_x;
                                r_hy   <= i_point.point_y;
                                r_hw   <= i_point.point_width;
                                r_seen <= 2'd1;
                            end
                        end else begin
                            r_cx     <= r_hx;
                            r_cy     <= r_hy;
                            r_cw     <= r_hw;
                            r_ax     <= j_zero ? NB'(1) : NB'(j_mx);
                            r_ay     <= NB'(j_my);
                            r_negx   <= j_nx && !j_zero;
                            r_negy   <= j_ny && !j_zero;
                            r_done   <= 1'b0;
                            r_last   <= !i_point.stroke_end;
                            r_second <= i_point.stroke_end;
                            r_sq     <= 1'b0;
                            r_bx     <= r_hx;
                            r_by     <= r_hy;
                            r_hx     <= i_point.point_x;
                            r_hy     <= i_point.point_y;
                            r_hw     <= i_point.point_width;
                            r_seen   <= i_point.stroke_end ? 2'd0 : 2'd2;
                            r_state  <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (m_big) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else if (m_small) begin
                        r_ax <= r_ax << 1;
                        r_ay <= r_ay << 1;
                    end else begin
                        r_state <= S_SQA;
                    end
                end
                S_SQA: begin
                    r_acc   <= AW'(mul_p);
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_rem   <= r_acc + AW'(mul_p);
                    r_root  <= '0;
                    r_bit   <= AW'(1) << srt_pkg::ROOT_START;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_rem >= rt_t) begin
                        r_rem  <= r_rem - rt_t;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_MULY;
                    end
                end
                S_MULY, S_MULX: begin
                    r_acc   <= acc_ge_sum;
                    r_den   <= AW'({len, 1'b0}) << (WB - 1);
                    r_cnt   <= CW'(WB - 1);
                    r_quo   <= '0;
                    r_state <= (r_state == S_MULY) ? S_DIVX : S_DIVY;
                end
                S_DIVX, S_DIVY: begin
                    if (div_ge) begin
                        r_acc <= r_acc - r_den;
                    end
                    r_quo <= {r_quo[WB-2:0], div_ge};
                    r_den <= r_den >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        if (r_state == S_DIVX) begin
                            r_ox    <= {r_quo[WB-2:0], div_ge};
                            r_state <= S_MULX;
                        end else begin
                            r_ux    <= r_negy ? $signed({1'b0, r_ox}) : -$signed({1'b0, r_ox});
                            r_uy    <= r_negx ? -$signed({1'b0, r_quo[WB-2:0], div_ge})
                                              : $signed({1'b0, r_quo[WB-2:0], div_ge});
                            r_vi    <= 2'd0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_oxv   <= e_vx;
                        r_oyv   <= e_vy;
                        r_odone <= e_fin && (r_sq || r_done);
                        r_olast <= e_fin && (r_sq || r_last);
                        r_vi    <= r_vi + 1'b1;
                        if (e_fin) begin
                            if (!r_sq && r_second) begin
                                r_cx     <= r_hx;
                                r_cy     <= r_hy;
                                r_cw     <= r_hw;
                                r_ax     <= j_zero ? NB'(1) : NB'(j_mx);
                                r_ay     <= NB'(j_my);
                                r_negx   <= j_nx && !j_zero;
                                r_negy   <= j_ny && !j_zero;
                                r_done   <= 1'b1;
                                r_last   <= 1'b1;
                                r_second <= 1'b0;
                                r_state  <= S_NORM;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
